>>> design/frp_pkg.sv
// Shared constants and types for the frame rate pacer.
package frp_pkg;

    localparam int STAMP_W  = 64;
    localparam int RATE_W   = 30;
    localparam int MS_W     = 32;
    localparam int TGT_W    = 13;
    localparam int PERIOD_W = 26;
    localparam int CREDIT_W = 27;
    localparam int DVD_W    = 64;
    localparam int DVS_W    = 30;
    localparam int STEP_W   = 7;
    localparam int SPAN_W   = 21;
    localparam int LIMB_W   = 32;
    localparam int MS_SHIFT = 4;
    localparam int RECIP_SH = 70;

    localparam int RING_DEPTH_DEF = 10;

    localparam logic [RATE_W-1:0]   RATE_SCALE   = 30'd1000000000;
    localparam logic [SPAN_W-1:0]   STARTUP_SPAN = 21'd2000000;
    localparam logic [RATE_W-1:0]   DEFAULT_RATE = 30'd3000;
    localparam logic [TGT_W-1:0]    RATE_MIN     = 13'd25;
    localparam logic [TGT_W-1:0]    RATE_MAX     = 13'd6000;
    localparam logic [TGT_W-1:0]    TGT_RESET    = 13'd1000;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 26'd1000000;

    // 10000 is 16 * 625: the 16 is shifted out, then the rest is a multiply by
    // 2^70 / 625 rounded up, which is exact for any shifted magnitude below 2^60.
    localparam logic [2*LIMB_W-1:0] MS_RECIP =
        64'(((128'd1 << RECIP_SH) + 128'd624) / 128'd625);

    localparam logic CFG_TARGET = 1'b0;
    localparam logic CFG_BYPASS = 1'b1;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } div_req_t;

endpackage

>>> design/frp_div.sv
// Shared restoring divider, one quotient bit per cycle.
module frp_div
    import frp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  div_req_t         req,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quot
);

    logic [DVS_W-1:0]  rem_reg, rem_next;
    logic [DVD_W-1:0]  dvd_reg, dvd_next;
    logic [DVS_W-1:0]  dvs_reg, dvs_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DVS_W:0]    shifted;
    logic              fits;

    // The dividend arrives left aligned; quotient bits shift in at the bottom.
    always_comb
    begin
        shifted   = {rem_reg, dvd_reg[DVD_W-1]};
        fits      = shifted >= {1'b0, dvs_reg};
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = '0;
            dvd_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = req.steps;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? DVS_W'(shifted - {1'b0, dvs_reg}) : shifted[DVS_W-1:0];
            dvd_next = {dvd_reg[DVD_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            dvd_reg  <= '0;
            dvs_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            rem_reg  <= rem_next;
            dvd_reg  <= dvd_next;
            dvs_reg  <= dvs_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done = done_reg;
    assign quot = dvd_reg;

endmodule

>>> design/frame_rate_pacer_unit.sv
// Frame rate pacer: one frame event at a time, one result beat per event.
// The time from input beat to result beat is spent mostly in the shared bit-serial divider
// for the rate and the ring average.
// A new input beat can be taken the cycle after the result is loaded, and a stalled result
// beat adds its wait. A target rate write blocks input until the pacing period is recomputed.
// Reset (asynchronous, active low) clears all history and loads target 1000, bypass off.
module frame_rate_pacer_unit
    import frp_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [STAMP_W-1:0] s_tdata,   // stamp
    input  logic [2:0]         s_tuser,   // cmd, payload_ok, already_marked
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [63:0]        m_tdata,   // avg_rate, stamp_ms, zero padding
    output logic [0:0]         m_tuser,   // deliver
    input  logic               cfg_we,
    input  logic [0:0]         cfg_index,
    input  logic [TGT_W-1:0]   cfg_data
);

    localparam int POS_W = $clog2(RING_DEPTH);
    localparam int CNT_W = $clog2(RING_DEPTH + 1);
    localparam int SUM_W = RATE_W + CNT_W;
    localparam int DIF_W = STAMP_W + 1;
    localparam int T_W   = STAMP_W + 2;
    localparam int ACC_W = 4 * LIMB_W;

    localparam logic [1:0] MUL_LAST = 2'd3;

    localparam logic [4:0] ST_IDLE   = 5'd0;
    localparam logic [4:0] ST_PWAIT  = 5'd1;
    localparam logic [4:0] ST_CHECK  = 5'd2;
    localparam logic [4:0] ST_DIFF   = 5'd3;
    localparam logic [4:0] ST_RDIV   = 5'd4;
    localparam logic [4:0] ST_RWAIT  = 5'd5;
    localparam logic [4:0] ST_RING   = 5'd6;
    localparam logic [4:0] ST_AVG    = 5'd7;
    localparam logic [4:0] ST_AWAIT  = 5'd8;
    localparam logic [4:0] ST_START  = 5'd9;
    localparam logic [4:0] ST_CDIFF  = 5'd10;
    localparam logic [4:0] ST_CSUB   = 5'd11;
    localparam logic [4:0] ST_CCLAMP = 5'd12;
    localparam logic [4:0] ST_CDEC   = 5'd13;
    localparam logic [4:0] ST_MS     = 5'd14;
    localparam logic [4:0] ST_MMUL   = 5'd15;
    localparam logic [4:0] ST_MNEG   = 5'd16;
    localparam logic [4:0] ST_FIN    = 5'd17;

    logic [4:0]                state_reg, state_next;
    logic signed [STAMP_W-1:0] stamp_reg, stamp_next;
    logic                      cmd_reg, cmd_next;
    logic                      ok_reg, ok_next;
    logic                      mark_reg, mark_next;
    logic signed [STAMP_W-1:0] prev_reg, prev_next;
    logic signed [STAMP_W-1:0] last_reg, last_next;
    logic signed [STAMP_W-1:0] first_reg, first_next;
    logic signed [STAMP_W-1:0] old_reg, old_next;
    logic [CREDIT_W-1:0]       credit_reg, credit_next;
    logic [RATE_W-1:0]         ring_reg [RING_DEPTH];
    logic                      ring_we;
    logic [POS_W-1:0]          pos_reg, pos_next;
    logic [SUM_W-1:0]          sum_reg, sum_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic [STAMP_W-1:0]        d_reg, d_next;
    logic [RATE_W-1:0]         rate_reg, rate_next;
    logic [RATE_W-1:0]         avg_reg, avg_next;
    logic [MS_W-1:0]           ms_reg, ms_next;
    logic                      del_reg, del_next;
    logic signed [DIF_W-1:0]   diff_reg, diff_next;
    logic signed [T_W-1:0]     t_reg, t_next;
    logic [TGT_W-1:0]          target_reg, target_next;
    logic                      bypass_reg, bypass_next;
    logic                      pend_reg, pend_next;
    logic [PERIOD_W-1:0]       period_reg, period_next;
    logic [STAMP_W-1:0]        msx_reg, msx_next;
    logic [ACC_W-1:0]          acc_reg, acc_next;
    logic [1:0]                mstep_reg, mstep_next;
    logic                      m_tvalid_reg, m_tvalid_next;
    logic [63:0]               m_tdata_reg, m_tdata_next;
    logic                      m_tuser_reg, m_tuser_next;

    div_req_t                  div_req;
    logic [DVD_W-1:0]          div_dividend;
    logic [DVS_W-1:0]          div_divisor;
    logic                      div_done;
    logic [DVD_W-1:0]          div_quot;

    logic                      accept;
    logic signed [DIF_W-1:0]   start_diff;
    logic [RATE_W-1:0]         old_entry;
    logic [CREDIT_W-1:0]       lim;
    logic [LIMB_W-1:0]         mul_a;
    logic [LIMB_W-1:0]         mul_b;
    logic [2*LIMB_W-1:0]       mul_p;
    logic [ACC_W-1:0]          mul_term;

    frp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quot     (div_quot)
    );

    assign s_tready = (state_reg == ST_IDLE) && !pend_reg;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    assign start_diff = {stamp_reg[STAMP_W-1], stamp_reg} - {first_reg[STAMP_W-1], first_reg};
    assign old_entry  = ring_reg[pos_reg];
    assign lim        = {period_reg, 1'b0};

    // One 32 by 32 partial product per cycle: low by low, high by low, low by high, high by high.
    assign mul_a = mstep_reg[0] ? msx_reg[2*LIMB_W-1:LIMB_W] : msx_reg[LIMB_W-1:0];
    assign mul_b = mstep_reg[1] ? MS_RECIP[2*LIMB_W-1:LIMB_W] : MS_RECIP[LIMB_W-1:0];
    assign mul_p = mul_a * mul_b;

    always_comb
    begin
        case (mstep_reg)
            2'd0:
            begin
                mul_term = {{(ACC_W-2*LIMB_W){1'b0}}, mul_p};
            end
            MUL_LAST:
            begin
                mul_term = {mul_p, {(ACC_W-2*LIMB_W){1'b0}}};
            end
            default:
            begin
                mul_term = {{(ACC_W-3*LIMB_W){1'b0}}, mul_p, {LIMB_W{1'b0}}};
            end
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        stamp_next    = stamp_reg;
        cmd_next      = cmd_reg;
        ok_next       = ok_reg;
        mark_next     = mark_reg;
        prev_next     = prev_reg;
        last_next     = last_reg;
        first_next    = first_reg;
        old_next      = old_reg;
        credit_next   = credit_reg;
        pos_next      = pos_reg;
        sum_next      = sum_reg;
        cnt_next      = cnt_reg;
        d_next        = d_reg;
        rate_next     = rate_reg;
        avg_next      = avg_reg;
        ms_next       = ms_reg;
        del_next      = del_reg;
        diff_next     = diff_reg;
        t_next        = t_reg;
        target_next   = target_reg;
        bypass_next   = bypass_reg;
        pend_next     = pend_reg;
        period_next   = period_reg;
        msx_next      = msx_reg;
        acc_next      = acc_reg;
        mstep_next    = mstep_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        ring_we       = 1'b0;
        div_req       = '0;
        div_dividend  = {RATE_SCALE, {(DVD_W-RATE_W){1'b0}}};
        div_divisor   = {{(DVS_W-TGT_W){1'b0}}, target_reg};

        if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (pend_reg)
                begin
                    // Recompute the pacing period after a target rate write.
                    div_req.start = 1'b1;
                    div_req.steps = STEP_W'(RATE_W);
                    pend_next     = 1'b0;
                    state_next    = ST_PWAIT;
                end
                else if (accept)
                begin
                    stamp_next = s_tdata;
                    cmd_next   = s_tuser[0];
                    ok_next    = s_tuser[1];
                    mark_next  = s_tuser[2];
                    state_next = ST_CHECK;
                end
            end
            ST_PWAIT:
            begin
                if (div_done)
                begin
                    period_next = div_quot[PERIOD_W-1:0];
                    state_next  = ST_IDLE;
                end
            end
            ST_CHECK:
            begin
                del_next = 1'b0;
                if (cmd_reg)
                begin
                    prev_next  = '0;
                    state_next = ST_FIN;
                end
                else if (!ok_reg || (mark_reg && !bypass_reg))
                begin
                    state_next = ST_FIN;
                end
                else if (stamp_reg <= prev_reg)
                begin
                    // A backwards step moves the previous time back with it.
                    if (stamp_reg != prev_reg)
                    begin
                        prev_next = stamp_reg;
                    end
                    state_next = ST_FIN;
                end
                else
                begin
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF:
            begin
                d_next     = $unsigned(stamp_reg) - $unsigned(prev_reg);
                state_next = ST_RDIV;
            end
            ST_RDIV:
            begin
                if (d_reg > {{(STAMP_W-RATE_W){1'b0}}, RATE_SCALE})
                begin
                    rate_next  = '0;
                    state_next = ST_RING;
                end
                else
                begin
                    div_req.start = 1'b1;
                    div_req.steps = STEP_W'(RATE_W);
                    div_divisor   = d_reg[DVS_W-1:0];
                    state_next    = ST_RWAIT;
                end
            end
            ST_RWAIT:
            begin
                if (div_done)
                begin
                    rate_next  = div_quot[RATE_W-1:0];
                    state_next = ST_RING;
                end
            end
            ST_RING:
            begin
                // Running sum and count of nonzero entries follow each overwrite.
                ring_we  = 1'b1;
                sum_next = sum_reg - SUM_W'(old_entry) + SUM_W'(rate_reg);
                cnt_next = cnt_reg - CNT_W'(old_entry != '0) + CNT_W'(rate_reg != '0);
                pos_next = (pos_reg == POS_W'(RING_DEPTH - 1)) ? '0 : pos_reg + 1'b1;
                prev_next = stamp_reg;
                old_next  = last_reg;
                last_next = stamp_reg;
                if (first_reg == '0)
                begin
                    first_next = stamp_reg;
                end
                state_next = ST_AVG;
            end
            ST_AVG:
            begin
                if (cnt_reg == '0)
                begin
                    avg_next   = DEFAULT_RATE;
                    state_next = ST_START;
                end
                else
                begin
                    div_req.start = 1'b1;
                    div_req.steps = STEP_W'(SUM_W);
                    div_dividend  = {sum_reg, {(DVD_W-SUM_W){1'b0}}};
                    div_divisor   = {{(DVS_W-CNT_W){1'b0}}, cnt_reg};
                    state_next    = ST_AWAIT;
                end
            end
            ST_AWAIT:
            begin
                if (div_done)
                begin
                    avg_next   = div_quot[RATE_W-1:0];
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                if (!bypass_reg && (start_diff < $signed(DIF_W'(STARTUP_SPAN))))
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    state_next = ST_CDIFF;
                end
            end
            ST_CDIFF:
            begin
                diff_next  = {stamp_reg[STAMP_W-1], stamp_reg} - {old_reg[STAMP_W-1], old_reg};
                state_next = ST_CSUB;
            end
            ST_CSUB:
            begin
                t_next     = {{(T_W-CREDIT_W){1'b0}}, credit_reg} - {diff_reg[DIF_W-1], diff_reg};
                state_next = ST_CCLAMP;
            end
            ST_CCLAMP:
            begin
                if (t_reg[T_W-1])
                begin
                    credit_next = '0;
                end
                else if (t_reg[T_W-2:0] > (T_W-1)'(lim))
                begin
                    credit_next = lim;
                end
                else
                begin
                    credit_next = t_reg[CREDIT_W-1:0];
                end
                state_next = ST_CDEC;
            end
            ST_CDEC:
            begin
                if (!bypass_reg && (credit_reg > CREDIT_W'(period_reg)))
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    credit_next = credit_reg + CREDIT_W'(period_reg);
                    state_next  = ST_MS;
                end
            end
            ST_MS:
            begin
                // Scale the magnitude by the reciprocal; the sign is put back afterwards.
                if (stamp_reg[STAMP_W-1])
                begin
                    msx_next = (STAMP_W'(0) - $unsigned(stamp_reg)) >> MS_SHIFT;
                end
                else
                begin
                    msx_next = $unsigned(stamp_reg) >> MS_SHIFT;
                end
                acc_next   = '0;
                mstep_next = '0;
                state_next = ST_MMUL;
            end
            ST_MMUL:
            begin
                acc_next   = acc_reg + mul_term;
                mstep_next = mstep_reg + 1'b1;
                if (mstep_reg == MUL_LAST)
                begin
                    state_next = ST_MNEG;
                end
            end
            ST_MNEG:
            begin
                if (stamp_reg[STAMP_W-1])
                begin
                    ms_next = MS_W'(0) - acc_reg[RECIP_SH+MS_W-1:RECIP_SH];
                end
                else
                begin
                    ms_next = acc_reg[RECIP_SH+MS_W-1:RECIP_SH];
                end
                del_next   = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = del_reg;
                    m_tdata_next  = del_reg ? {2'b00, ms_reg, avg_reg} : '0;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_TARGET:
                begin
                    if (cfg_data < RATE_MIN)
                    begin
                        target_next = RATE_MIN;
                    end
                    else if (cfg_data > RATE_MAX)
                    begin
                        target_next = RATE_MAX;
                    end
                    else
                    begin
                        target_next = cfg_data;
                    end
                    pend_next = 1'b1;
                end
                CFG_BYPASS:
                begin
                    bypass_next = cfg_data[0];
                end
                default:
                begin
                    bypass_next = bypass_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            stamp_reg    <= '0;
            cmd_reg      <= 1'b0;
            ok_reg       <= 1'b0;
            mark_reg     <= 1'b0;
            prev_reg     <= '0;
            last_reg     <= '0;
            first_reg    <= '0;
            old_reg      <= '0;
            credit_reg   <= '0;
            pos_reg      <= '0;
            sum_reg      <= '0;
            cnt_reg      <= '0;
            d_reg        <= '0;
            rate_reg     <= '0;
            avg_reg      <= '0;
            ms_reg       <= '0;
            del_reg      <= 1'b0;
            diff_reg     <= '0;
            t_reg        <= '0;
            target_reg   <= TGT_RESET;
            bypass_reg   <= 1'b0;
            pend_reg     <= 1'b0;
            period_reg   <= PERIOD_RESET;
            msx_reg      <= '0;
            acc_reg      <= '0;
            mstep_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            m_tuser_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            stamp_reg    <= stamp_next;
            cmd_reg      <= cmd_next;
            ok_reg       <= ok_next;
            mark_reg     <= mark_next;
            prev_reg     <= prev_next;
            last_reg     <= last_next;
            first_reg    <= first_next;
            old_reg      <= old_next;
            credit_reg   <= credit_next;
            pos_reg      <= pos_next;
            sum_reg      <= sum_next;
            cnt_reg      <= cnt_next;
            d_reg        <= d_next;
            rate_reg     <= rate_next;
            avg_reg      <= avg_next;
            ms_reg       <= ms_next;
            del_reg      <= del_next;
            diff_reg     <= diff_next;
            t_reg        <= t_next;
            target_reg   <= target_next;
            bypass_reg   <= bypass_next;
            pend_reg     <= pend_next;
            period_reg   <= period_next;
            msx_reg      <= msx_next;
            acc_reg      <= acc_next;
            mstep_reg    <= mstep_next;
            m_tvalid_reg <= m_tvalid_next;
            m_tdata_reg  <= m_tdata_next;
            m_tuser_reg  <= m_tuser_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < RING_DEPTH; i++)
            begin
                ring_reg[i] <= '0;
            end
        end
        else if (ring_we)
        begin
            ring_reg[pos_reg] <= rate_reg;
        end
    end

endmodule

>>> dv/frame_pacing_checker.sv
// Checker for the frame rate pacer: predicts each result beat and compares it.
module frame_pacing_checker
    import frp_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    input  logic               s_tready,
    input  logic [STAMP_W-1:0] s_tdata,   // stamp
    input  logic [2:0]         s_tuser,   // cmd, payload_ok, already_marked
    input  logic               m_tvalid,
    input  logic               m_tready,
    input  logic [63:0]        m_tdata,   // avg_rate, stamp_ms, zero padding
    input  logic [0:0]         m_tuser,   // deliver
    input  logic               cfg_we,
    input  logic [0:0]         cfg_index,
    input  logic [TGT_W-1:0]   cfg_data,
    output int                 fail_count,
    output int                 open_count
);

    typedef struct packed {
        logic              deliver;
        logic [RATE_W-1:0] avg_rate;
        logic [MS_W-1:0]   stamp_ms;
    } pace_verdict_t;

    pace_verdict_t verdicts_q[$];
    pace_verdict_t want;
    int            beat_no;

    logic [TGT_W-1:0]  target_q;
    logic              bypass_q;
    longint            prev_stamp_q;
    longint            last_seen_q;
    longint            first_q;
    logic [63:0]       credit_q;
    logic [RATE_W-1:0] rate_ring_q [RING_DEPTH];
    int                ring_pos_q;

    task automatic report(input string msg);
        fail_count++;
        if (fail_count <= 40)
            $display("mismatch at beat %0d: %s", beat_no, msg);
    endtask

    task automatic clear_history();
        target_q     = TGT_RESET;
        bypass_q     = 1'b0;
        prev_stamp_q = 0;
        last_seen_q  = 0;
        first_q      = 0;
        credit_q     = '0;
        for (int i = 0; i < RING_DEPTH; i++)
            rate_ring_q[i] = '0;
        ring_pos_q   = 0;
    endtask

    // Advances the pacer state by one event and returns the beat it should produce.
    function automatic pace_verdict_t pace_frame(input logic cmd, input longint stamp,
                                                 input logic ok, input logic marked);
        pace_verdict_t v;
        logic [63:0]   d;
        logic [63:0]   period;
        logic [63:0]   lim;
        logic [63:0]   ring_sum;
        logic [63:0]   ring_cnt;
        logic [RATE_W-1:0] avg;
        longint        prior;
        longint        ms;
        v = '0;
        if (cmd) begin
            prev_stamp_q = 0;
            return v;
        end
        if (!ok || (marked && !bypass_q))
            return v;
        if (stamp <= prev_stamp_q) begin
            if (stamp < prev_stamp_q)
                prev_stamp_q = stamp;
            return v;
        end

        d = stamp - prev_stamp_q;
        if (ring_pos_q >= RING_DEPTH)
            ring_pos_q = 0;
        rate_ring_q[ring_pos_q] = RATE_W'(64'(RATE_SCALE) / d);
        ring_sum = '0;
        ring_cnt = '0;
        for (int i = 0; i < RING_DEPTH; i++) begin
            ring_sum += rate_ring_q[i];
            ring_cnt += (rate_ring_q[i] != '0);
        end
        avg = (ring_cnt != 0) ? RATE_W'(ring_sum / ring_cnt) : DEFAULT_RATE;
        ring_pos_q++;
        if (ring_pos_q >= RING_DEPTH)
            ring_pos_q = 0;

        prev_stamp_q = stamp;
        prior        = last_seen_q;
        last_seen_q  = stamp;

        // A first stamp of zero still counts as unset on the next frame.
        if (first_q == 0)
            first_q = stamp;
        d = stamp - first_q;
        if (!bypass_q && (stamp < first_q || d < 64'(STARTUP_SPAN)))
            return v;

        period = 64'(RATE_SCALE) / 64'(target_q);
        lim    = period * 2;
        if (stamp >= prior) begin
            d = stamp - prior;
            credit_q = (d >= credit_q) ? '0 : credit_q - d;
            if (credit_q > lim)
                credit_q = lim;
        end
        else begin
            d = prior - stamp;
            if (credit_q >= lim || d >= lim - credit_q)
                credit_q = lim;
            else
                credit_q += d;
        end
        if (credit_q > period && !bypass_q)
            return v;
        credit_q += period;

        ms = stamp / 64'sd10000;
        v.deliver  = 1'b1;
        v.avg_rate = avg;
        v.stamp_ms = ms[MS_W-1:0];
        return v;
    endfunction

    initial
    begin
        fail_count = 0;
        open_count = 0;
        beat_no    = 0;
        clear_history();
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            clear_history();
            verdicts_q.delete();
        end
        else begin
            if (cfg_we) begin
                if (cfg_index == CFG_TARGET) begin
                    if (cfg_data < RATE_MIN)
                        target_q = RATE_MIN;
                    else if (cfg_data > RATE_MAX)
                        target_q = RATE_MAX;
                    else
                        target_q = cfg_data;
                end
                else begin
                    bypass_q = cfg_data[0];
                end
            end

            if (m_tvalid && m_tready) begin
                if (verdicts_q.size() == 0) begin
                    report("result beat with nothing expected");
                end
                else begin
                    want = verdicts_q.pop_front();
                    if (m_tuser[0] !== want.deliver)
                        report($sformatf("deliver %b, expected %b", m_tuser[0], want.deliver));
                    if (m_tdata[29:0] !== want.avg_rate)
                        report($sformatf("avg_rate %0d, expected %0d",
                                         m_tdata[29:0], want.avg_rate));
                    if (m_tdata[61:30] !== want.stamp_ms)
                        report($sformatf("stamp_ms %h, expected %h",
                                         m_tdata[61:30], want.stamp_ms));
                end
                beat_no++;
            end

            if (s_tvalid && s_tready)
                verdicts_q.push_back(pace_frame(s_tuser[0], s_tdata, s_tuser[1], s_tuser[2]));
        end
        open_count = verdicts_q.size();
    end

endmodule

>>> dv/tb_frame_rate_pacer_unit.sv
// Testbench top for the frame rate pacer: stimulus, flow control and verdict.
module tb_frame_rate_pacer_unit;
    import frp_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    logic [STAMP_W-1:0] s_tdata   = '0;   // stamp
    logic [2:0]         s_tuser   = '0;   // cmd, payload_ok, already_marked
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    logic [63:0]        m_tdata;          // avg_rate, stamp_ms, zero padding
    logic [0:0]         m_tuser;          // deliver
    logic               cfg_we    = 1'b0;
    logic [0:0]         cfg_index = '0;
    logic [TGT_W-1:0]   cfg_data  = '0;

    int          fail_count;
    int          open_count;
    int unsigned cycles     = 0;
    int          burst_left = 0;
    int          stall_mode = 0;
    int          tgt_eff    = 1000;
    longint      clock_now;

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
    end

    frame_rate_pacer_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    frame_pacing_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .open_count (open_count)
    );

    // The receiver switches at random between stall patterns: always ready, random, mostly ready and periodic.
    always @(negedge clk)
    begin
        if (cycles % 384 == 0)
            stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= ($urandom_range(0, 7) != 0);
            default: m_tready <= ((cycles % 16) >= 5);
        endcase
    end

    initial
    begin
        wait (cycles >= CYCLE_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_event(input logic cmd, input logic [63:0] stamp,
                              input logic ok, input logic marked);
        int gap;
        if (burst_left == 0) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: gap = $urandom_range(0, 4);
                6, 7, 8:          gap = $urandom_range(5, 60);
                default:          gap = $urandom_range(61, 300);
            endcase
            burst_left = $urandom_range(1, 40);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= stamp;
        s_tuser  <= {marked, ok, cmd};
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        burst_left--;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (open_count != 0)
            @(negedge clk);
        @(negedge clk);
    endtask

    task automatic set_reg(input logic [0:0] idx, input logic [TGT_W-1:0] val);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == CFG_TARGET)
            tgt_eff = (val < RATE_MIN) ? RATE_MIN : (val > RATE_MAX) ? RATE_MAX : val;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin
        int          kind;
        longint      per;
        logic        cmd;
        logic        ok;
        logic        marked;
        logic [63:0] stamp;
        logic [TGT_W-1:0] tgt;

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: pause, equal, backwards, a zero first stamp, missing payload,
        // marked frames, startup skip, pacing drop, stamp extremes and wide steps.
        send_event(1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1);
        send_event(1'b0, 64'd0, 1'b1, 1'b0);
        send_event(1'b0, -64'sd2000, 1'b1, 1'b0);
        send_event(1'b0, 64'd0, 1'b1, 1'b0);
        send_event(1'b0, 64'd1000, 1'b0, 1'b0);
        send_event(1'b0, 64'd1000, 1'b1, 1'b1);
        send_event(1'b0, 64'd1000, 1'b1, 1'b0);
        send_event(1'b0, 64'd1000, 1'b1, 1'b0);
        send_event(1'b0, 64'd500, 1'b1, 1'b0);
        send_event(1'b0, 64'd3000000, 1'b1, 1'b0);
        send_event(1'b0, 64'd3000001, 1'b1, 1'b0);
        send_event(1'b0, 64'd3000002, 1'b1, 1'b0);
        send_event(1'b0, -64'sd123456789, 1'b1, 1'b0);
        send_event(1'b0, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 1'b0);
        send_event(1'b0, 64'h8000_0000_0000_0000, 1'b1, 1'b0);
        send_event(1'b0, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 1'b0);
        send_event(1'b1, 64'd0, 1'b0, 1'b0);
        send_event(1'b0, -64'sd5, 1'b1, 1'b0);
        send_event(1'b0, 64'd3, 1'b1, 1'b0);
        set_reg(CFG_BYPASS, 13'd1);
        send_event(1'b0, 64'd4, 1'b1, 1'b1);
        send_event(1'b0, 64'd5000000, 1'b1, 1'b1);
        send_event(1'b0, -64'sd20000000, 1'b1, 1'b0);
        send_event(1'b0, -64'sd19990001, 1'b1, 1'b1);
        send_event(1'b1, 64'd0, 1'b0, 1'b1);

        clock_now = 50000000;
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0:       tgt = 13'd0;
                1:       tgt = 13'h1FFF;
                2:       tgt = RATE_MIN;
                3:       tgt = RATE_MAX;
                4:       tgt = 13'd24;
                5:       tgt = 13'd6001;
                default: tgt = TGT_W'($urandom_range(0, 8191));
            endcase
            set_reg(CFG_TARGET, tgt);
            set_reg(CFG_BYPASS, TGT_W'(phase[0] ^ (phase > 5)));
            per = 1000000000 / tgt_eff;

            for (int n = 0; n < 205; n++) begin
                kind   = $urandom_range(0, 99);
                cmd    = 1'b0;
                ok     = 1'b1;
                marked = ($urandom_range(0, 9) == 0);
                if (kind < 78) begin
                    // Regular frames spaced around the target period.
                    clock_now += per * $urandom_range(30, 170) / 100 + $urandom_range(0, 999);
                    stamp = clock_now;
                end
                else if (kind < 83) begin
                    cmd    = 1'b1;
                    stamp  = {$urandom, $urandom};
                    ok     = 1'($urandom_range(0, 1));
                    marked = 1'($urandom_range(0, 1));
                end
                else if (kind < 86) begin
                    stamp = clock_now;
                end
                else if (kind < 90) begin
                    clock_now -= $urandom_range(1, 2000000);
                    stamp = clock_now;
                end
                else if (kind < 93) begin
                    ok    = 1'b0;
                    stamp = {$urandom, $urandom};
                end
                else if (kind < 96) begin
                    clock_now = {$urandom, $urandom};
                    stamp = clock_now;
                end
                else begin
                    clock_now += longint'($urandom) * $urandom_range(1, 4096);
                    stamp = clock_now;
                end
                if ($urandom_range(0, 99) == 0)
                    drain();
                send_event(cmd, stamp, ok, marked);
            end
        end

        drain();
        repeat (200) @(negedge clk);
        if (fail_count == 0 && open_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
